FILE: sv/mm64_pkg.sv
package mm64_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned NB_W   = 4;
    localparam int unsigned LEN_W  = 32;

    localparam logic [WORD_W-1:0] MUL_M   = 64'hc6a4a7935bd1e995;
    localparam logic [HALF_W-1:0] MUL_M_LO = MUL_M[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MUL_M_HI = MUL_M[WORD_W-1:HALF_W];
    localparam int unsigned SHIFT_R = 47;
    localparam logic [NB_W-1:0] FULL_BYTES = 4'd8;

    // sub-cycles of one multiply by MUL_M
    typedef logic [1:0] phase_t;
    localparam phase_t PH_LOAD   = 2'd0;
    localparam phase_t PH_LOW    = 2'd1;
    localparam phase_t PH_CROSS1 = 2'd2;
    localparam phase_t PH_CROSS2 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEED,
        S_MIX1,
        S_MIX2,
        S_FOLD,
        S_PART,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_SEED,
        OP_MIX1,
        OP_MIX2,
        OP_FOLD,
        OP_PART,
        OP_FIN
    } op_t;

    typedef struct packed {
        logic   load;
        logic   run;
        logic   wr;
        op_t    op;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic zero;
        logic last;
    } status_t;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] x);
        return x ^ (x >> SHIFT_R);
    endfunction

endpackage

FILE: sv/mm64_if.sv
interface mm64_word_if;
    logic                                 valid;
    logic                                 ready;
    logic [mm64_pkg::WORD_W-1:0]          data_word;
    logic [mm64_pkg::NB_W-1:0]            valid_bytes;
    logic [mm64_pkg::LEN_W-1:0]           message_length;
    logic                                 last_word;

    modport source (
        output valid, data_word, valid_bytes, message_length, last_word,
        input  ready
    );
    modport sink (
        input  valid, data_word, valid_bytes, message_length, last_word,
        output ready
    );
endinterface

interface mm64_hash_if;
    logic                        valid;
    logic                        ready;
    logic [mm64_pkg::WORD_W-1:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

FILE: sv/murmur64a_hash_unit.sv
// channel   | direction | payload
// word_ch   | sink      | data_word, valid_bytes, message_length, last_word
// hash_ch   | source    | hash_value
//
// every multiply by the constant runs on one shared 32x32 multiplier in phases PH_LOAD .. PH_CROSS2
// a word is taken in, then gets the seed multiply if it is a first word
// or a dispatch step if it is a later word, then MIX1, MIX2 and FOLD for a full word,
// PART for a partial word, nothing for an empty one, and FIN on a last word
// rst_n clears the controller and the message flag asynchronously
// a new word is taken while the hash still waits; finalize stalls on a held hash

module murmur64a_hash_unit (
    input  logic           clk,
    input  logic           rst_n,
    mm64_word_if.sink      word_ch,
    mm64_hash_if.source    hash_ch
);

    mm64_pkg::cmd_t    cmd;
    mm64_pkg::status_t status;

    mm64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (word_ch.valid),
        .in_ready  (word_ch.ready),
        .out_valid (hash_ch.valid),
        .out_ready (hash_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mm64_datapath u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .data_word      (word_ch.data_word),
        .valid_bytes    (word_ch.valid_bytes),
        .message_length (word_ch.message_length),
        .last_word      (word_ch.last_word),
        .status         (status),
        .hash_value     (hash_ch.hash_value)
    );

endmodule

FILE: sv/mm64_ctrl.sv
module mm64_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mm64_pkg::status_t  status,
    output mm64_pkg::cmd_t     cmd
);

    mm64_pkg::state_t state_reg, state_next;
    mm64_pkg::phase_t phase_reg, phase_next;
    logic             in_msg_reg, in_msg_next;
    logic             out_valid_reg, out_valid_next;

    logic             in_fire;
    logic             active;
    logic             stall;
    logic             done;
    mm64_pkg::state_t after_load;
    mm64_pkg::state_t after_fold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mm64_pkg::S_IDLE;
            phase_reg     <= mm64_pkg::PH_LOAD;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        in_fire = (state_reg == mm64_pkg::S_IDLE) && in_valid;
        active  = (state_reg != mm64_pkg::S_IDLE) && (state_reg != mm64_pkg::S_DISPATCH);
        // finalize cannot overwrite a hash that is still waiting
        stall   = (state_reg == mm64_pkg::S_FIN) && out_valid_reg && !out_ready;
        done    = active && (phase_reg == mm64_pkg::PH_CROSS2) && !stall;

        // what the word needs once the start state is known
        if (status.full)
            after_load = mm64_pkg::S_MIX1;
        else if (!status.zero)
            after_load = mm64_pkg::S_PART;
        else if (status.last)
            after_load = mm64_pkg::S_FIN;
        else
            after_load = mm64_pkg::S_IDLE;

        after_fold = status.last ? mm64_pkg::S_FIN : mm64_pkg::S_IDLE;

        state_next = state_reg;
        case (state_reg)
            mm64_pkg::S_IDLE:
            begin
                if (in_fire)
                    state_next = in_msg_reg ? mm64_pkg::S_DISPATCH : mm64_pkg::S_SEED;
            end
            mm64_pkg::S_DISPATCH: state_next = after_load;
            mm64_pkg::S_SEED:     if (done) state_next = after_load;
            mm64_pkg::S_MIX1:     if (done) state_next = mm64_pkg::S_MIX2;
            mm64_pkg::S_MIX2:     if (done) state_next = mm64_pkg::S_FOLD;
            mm64_pkg::S_FOLD:     if (done) state_next = after_fold;
            mm64_pkg::S_PART:     if (done) state_next = after_fold;
            mm64_pkg::S_FIN:      if (done) state_next = mm64_pkg::S_IDLE;
            default:              state_next = mm64_pkg::S_IDLE;
        endcase

        if (!active || done)
            phase_next = mm64_pkg::PH_LOAD;
        else if (stall)
            phase_next = phase_reg;
        else
            phase_next = phase_reg + 2'd1;

        in_msg_next = in_msg_reg;
        if (in_fire)
            in_msg_next = 1'b1;
        else if (done && state_reg == mm64_pkg::S_FIN)
            in_msg_next = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        if (done && state_reg == mm64_pkg::S_FIN)
            out_valid_next = 1'b1;

        case (state_reg)
            mm64_pkg::S_SEED: cmd.op = mm64_pkg::OP_SEED;
            mm64_pkg::S_MIX1: cmd.op = mm64_pkg::OP_MIX1;
            mm64_pkg::S_MIX2: cmd.op = mm64_pkg::OP_MIX2;
            mm64_pkg::S_FOLD: cmd.op = mm64_pkg::OP_FOLD;
            mm64_pkg::S_PART: cmd.op = mm64_pkg::OP_PART;
            mm64_pkg::S_FIN:  cmd.op = mm64_pkg::OP_FIN;
            default:          cmd.op = mm64_pkg::OP_SEED;
        endcase
        cmd.load  = in_fire;
        // a held phase must not accumulate twice
        cmd.run   = active && !stall;
        cmd.wr    = done;
        cmd.phase = phase_reg;

        in_ready  = (state_reg == mm64_pkg::S_IDLE);
        out_valid = out_valid_reg;
    end

endmodule

FILE: sv/mm64_datapath.sv
module mm64_datapath (
    input  logic                           clk,
    input  mm64_pkg::cmd_t                 cmd,
    input  logic [mm64_pkg::WORD_W-1:0]    data_word,
    input  logic [mm64_pkg::NB_W-1:0]      valid_bytes,
    input  logic [mm64_pkg::LEN_W-1:0]     message_length,
    input  logic                           last_word,
    output mm64_pkg::status_t              status,
    output logic [mm64_pkg::WORD_W-1:0]    hash_value
);

    localparam int unsigned NBYTES = mm64_pkg::WORD_W / 8;

    logic [mm64_pkg::WORD_W-1:0] word_reg;
    logic [mm64_pkg::NB_W-1:0]   nb_reg;
    logic [mm64_pkg::LEN_W-1:0]  len_reg;
    logic                        last_reg;
    logic [mm64_pkg::WORD_W-1:0] h_reg;
    logic [mm64_pkg::WORD_W-1:0] k_reg;
    logic [mm64_pkg::WORD_W-1:0] op_reg;
    logic [mm64_pkg::WORD_W-1:0] acc_reg;
    logic [mm64_pkg::WORD_W-1:0] hash_reg;

    logic [mm64_pkg::NB_W-1:0]   nb_sat;
    logic [mm64_pkg::WORD_W-1:0] masked;
    logic [mm64_pkg::WORD_W-1:0] src;
    logic [mm64_pkg::HALF_W-1:0] mul_a;
    logic [mm64_pkg::HALF_W-1:0] mul_b;
    logic [mm64_pkg::WORD_W-1:0] prod;
    logic [mm64_pkg::WORD_W-1:0] result;

    always_comb
    begin
        nb_sat = (valid_bytes > mm64_pkg::FULL_BYTES) ? mm64_pkg::FULL_BYTES : valid_bytes;

        for (int i = 0; i < NBYTES; i++)
        begin
            masked[8*i +: 8] = (mm64_pkg::NB_W'(i) < nb_reg) ? word_reg[8*i +: 8] : 8'h00;
        end

        case (cmd.op)
            mm64_pkg::OP_SEED: src = {{(mm64_pkg::WORD_W-mm64_pkg::LEN_W){1'b0}}, len_reg};
            mm64_pkg::OP_MIX1: src = word_reg;
            mm64_pkg::OP_MIX2: src = k_reg;
            mm64_pkg::OP_FOLD: src = h_reg ^ k_reg;
            mm64_pkg::OP_PART: src = h_reg ^ masked;
            mm64_pkg::OP_FIN:  src = mm64_pkg::xorshift(h_reg);
            default:           src = word_reg;
        endcase

        // one 32x32 multiplier; only the low 64 bits of the product are kept
        mul_a = (cmd.phase == mm64_pkg::PH_CROSS2) ? op_reg[mm64_pkg::WORD_W-1:mm64_pkg::HALF_W]
                                                   : op_reg[mm64_pkg::HALF_W-1:0];
        mul_b = (cmd.phase == mm64_pkg::PH_CROSS1) ? mm64_pkg::MUL_M_HI : mm64_pkg::MUL_M_LO;
        prod  = {{mm64_pkg::HALF_W{1'b0}}, mul_a} * {{mm64_pkg::HALF_W{1'b0}}, mul_b};

        result = {acc_reg[mm64_pkg::WORD_W-1:mm64_pkg::HALF_W] + prod[mm64_pkg::HALF_W-1:0],
                  acc_reg[mm64_pkg::HALF_W-1:0]};

        status.full = nb_reg[mm64_pkg::NB_W-1];
        status.zero = (nb_reg == '0);
        status.last = last_reg;
        hash_value  = hash_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= data_word;
            nb_reg   <= nb_sat;
            len_reg  <= message_length;
            last_reg <= last_word;
        end

        if (cmd.run)
        begin
            case (cmd.phase)
                mm64_pkg::PH_LOAD:   op_reg <= src;
                mm64_pkg::PH_LOW:    acc_reg <= prod;
                mm64_pkg::PH_CROSS1: acc_reg[mm64_pkg::WORD_W-1:mm64_pkg::HALF_W] <=
                    acc_reg[mm64_pkg::WORD_W-1:mm64_pkg::HALF_W] + prod[mm64_pkg::HALF_W-1:0];
                default: ;
            endcase
        end

        if (cmd.wr)
        begin
            case (cmd.op)
                mm64_pkg::OP_SEED: h_reg    <= result;
                mm64_pkg::OP_MIX1: k_reg    <= mm64_pkg::xorshift(result);
                mm64_pkg::OP_MIX2: k_reg    <= result;
                mm64_pkg::OP_FOLD: h_reg    <= result;
                mm64_pkg::OP_PART: h_reg    <= result;
                mm64_pkg::OP_FIN:  hash_reg <= mm64_pkg::xorshift(result);
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/mm64_checker.sv
module mm64_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mm64_pkg::WORD_W-1:0] hash_value
);

    // a stalled hash stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("hash dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hash_value))
        else $error("hash changed while stalled");

    // one word at a time: after a transaction the input closes
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input open right after a transaction");

    // a hash only appears at the end of finalize, while the input is closed
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("hash appeared without finalize");

endmodule

bind murmur64a_hash_unit mm64_checker u_mm64_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (word_ch.valid),
    .in_ready   (word_ch.ready),
    .out_valid  (hash_ch.valid),
    .out_ready  (hash_ch.ready),
    .hash_value (hash_ch.hash_value)
);

FILE: tb/murmur64a_hash_unit_tb.sv
`timescale 1ns / 100ps

module murmur64a_hash_unit_tb;

    localparam int WORD_TARGET  = 1800;
    localparam int CALM_WORDS   = 300;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 40;
    localparam int NUM_DIRECTED = 23;

    localparam logic [mm64_pkg::WORD_W-1:0] ONES = {mm64_pkg::WORD_W{1'b1}};

    typedef struct packed {
        logic [mm64_pkg::WORD_W-1:0] data_word;
        logic [mm64_pkg::NB_W-1:0]   valid_bytes;
        logic [mm64_pkg::LEN_W-1:0]  message_length;
        logic                        last_word;
    } word_item_t;

    typedef enum bit {
        BY_MODEL,
        FIXED_DIGEST
    } digest_src_t;

    typedef struct packed {
        word_item_t                  item;
        digest_src_t                 src;
        logic [mm64_pkg::WORD_W-1:0] digest;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    mm64_word_if word_ch ();
    mm64_hash_if hash_ch ();

    murmur64a_hash_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .word_ch (word_ch),
        .hash_ch (hash_ch)
    );

    // running hash of the message in flight, as the block should hold it
    logic [mm64_pkg::WORD_W-1:0] acc_hash = '0;
    bit                          msg_open = 1'b0;

    logic [mm64_pkg::WORD_W-1:0] digest_q [$];
    logic [mm64_pkg::WORD_W-1:0] digest_head;

    int  errors         = 0;
    int  words_sent     = 0;
    int  hashes_checked = 0;
    int  stall_cycles   = 0;
    bit  src_idle_en;
    bit  snk_idle_en;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // empty messages
        '{'{64'h0, 4'd0, 32'd0, 1'b1}, FIXED_DIGEST, 64'h0},
        '{'{ONES, 4'd0, 32'hffff_ffff, 1'b1}, BY_MODEL, 64'h0},
        // single full words
        '{'{64'h0, 4'd8, 32'd0, 1'b1}, FIXED_DIGEST, 64'h0},
        '{'{ONES, 4'd8, 32'd8, 1'b1}, BY_MODEL, 64'h0},
        // 15-byte message, tail of 7 bytes, later length ignored
        '{'{64'h0123_4567_89ab_cdef, 4'd8, 32'd15, 1'b0}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd7, 32'hffff_ffff, 1'b1}, BY_MODEL, 64'h0},
        // single partial words, mask on all-ones data
        '{'{ONES, 4'd1, 32'd1, 1'b1}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd2, 32'd2, 1'b1}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd3, 32'd3, 1'b1}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd4, 32'd4, 1'b1}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd5, 32'd5, 1'b1}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd6, 32'd6, 1'b1}, BY_MODEL, 64'h0},
        // byte counts above eight saturate to a full word
        '{'{ONES, 4'd15, 32'd8, 1'b1}, BY_MODEL, 64'h0},
        '{'{64'ha5a5_5a5a_f00f_0ff0, 4'd9, 32'd8, 1'b1}, BY_MODEL, 64'h0},
        // partial word before the last one
        '{'{64'hdead_beef_cafe_f00d, 4'd3, 32'd11, 1'b0}, BY_MODEL, 64'h0},
        '{'{64'h1357_9bdf_2468_ace0, 4'd8, 32'h1234_5678, 1'b1}, BY_MODEL, 64'h0},
        // zero bytes in the middle of a message
        '{'{64'h0f1e_2d3c_4b5a_6978, 4'd8, 32'd16, 1'b0}, BY_MODEL, 64'h0},
        '{'{ONES, 4'd0, 32'hffff_ffff, 1'b0}, BY_MODEL, 64'h0},
        '{'{64'h8765_4321_fedc_ba98, 4'd8, 32'd0, 1'b1}, BY_MODEL, 64'h0},
        // single-word edge cases; the first and last state a length that disagrees with the bytes sent
        '{'{64'h5555_aaaa_5555_aaaa, 4'd8, 32'h8000_0000, 1'b1}, BY_MODEL, 64'h0},
        '{'{64'h8000_0000_0000_0000, 4'd8, 32'd8, 1'b1}, BY_MODEL, 64'h0},
        '{'{64'h1, 4'd1, 32'd1, 1'b1}, BY_MODEL, 64'h0},
        '{'{64'h0, 4'd3, 32'd0, 1'b1}, FIXED_DIGEST, 64'h0}
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // advances the message state by one word; returns 1 when a hash comes out
    function automatic bit fold_word(input word_item_t it,
                                     output logic [mm64_pkg::WORD_W-1:0] digest);
        logic [mm64_pkg::WORD_W-1:0] h;
        logic [mm64_pkg::WORD_W-1:0] k;
        logic [mm64_pkg::WORD_W-1:0] keep;
        logic [mm64_pkg::NB_W-1:0]   nb;
        nb = (it.valid_bytes > mm64_pkg::FULL_BYTES) ? mm64_pkg::FULL_BYTES : it.valid_bytes;
        h = msg_open ? acc_hash
                     : {{(mm64_pkg::WORD_W-mm64_pkg::LEN_W){1'b0}}, it.message_length}
                       * mm64_pkg::MUL_M;
        if (nb == mm64_pkg::FULL_BYTES)
        begin
            k = it.data_word * mm64_pkg::MUL_M;
            k = k ^ (k >> mm64_pkg::SHIFT_R);
            k = k * mm64_pkg::MUL_M;
            h = (h ^ k) * mm64_pkg::MUL_M;
        end
        else if (nb != '0)
        begin
            keep = (64'd1 << (8 * nb)) - 64'd1;
            h = (h ^ (it.data_word & keep)) * mm64_pkg::MUL_M;
        end
        digest = '0;
        if (it.last_word)
        begin
            h = h ^ (h >> mm64_pkg::SHIFT_R);
            h = h * mm64_pkg::MUL_M;
            h = h ^ (h >> mm64_pkg::SHIFT_R);
            digest = h;
            acc_hash = '0;
            msg_open = 1'b0;
            return 1'b1;
        end
        acc_hash = h;
        msg_open = 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [mm64_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES;
            2: return 64'd1 << $urandom_range(0, mm64_pkg::WORD_W-1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input word_item_t it, input digest_src_t src,
                             input logic [mm64_pkg::WORD_W-1:0] fixed);
        logic [mm64_pkg::WORD_W-1:0] digest;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            word_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        if (fold_word(it, digest))
            digest_q.push_back((src == FIXED_DIGEST) ? fixed : digest);
        word_ch.valid          <= 1'b1;
        word_ch.data_word      <= it.data_word;
        word_ch.valid_bytes    <= it.valid_bytes;
        word_ch.message_length <= it.message_length;
        word_ch.last_word      <= it.last_word;
        do
            @(posedge clk);
        while (word_ch.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic send_message();
        word_item_t  it;
        int unsigned len;
        int unsigned nfull;
        int unsigned nwords;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        snk_idle_en = (words_sent < WORD_TARGET - CALM_WORDS);
        src_idle_en = snk_idle_en && ($urandom_range(0, 3) != 0);
        if (pick < 80)
        begin
            // well-formed message, length matches the bytes sent
            if (pick < 50)
                len = $urandom_range(0, 32);
            else if (pick < 75)
                len = $urandom_range(33, 96);
            else
                len = $urandom_range(97, 255);
            nfull  = len / 8;
            nwords = (len == 0) ? 1 : (len + 7) / 8;
            for (int i = 0; i < nwords; i++)
            begin
                it.data_word      = rand_word();
                it.valid_bytes    = (i < nfull) ? mm64_pkg::FULL_BYTES
                                                : mm64_pkg::NB_W'(len % 8);
                it.message_length = (i == 0) ? mm64_pkg::LEN_W'(len)
                                             : mm64_pkg::LEN_W'($urandom);
                it.last_word      = (i == nwords - 1);
                send_word(it, BY_MODEL, '0);
            end
        end
        else
        begin
            // malformed run: odd byte counts, stray lengths, early last
            nwords = $urandom_range(1, 6);
            for (int i = 0; i < nwords; i++)
            begin
                it.data_word      = rand_word();
                it.valid_bytes    = mm64_pkg::NB_W'($urandom_range(0, 15));
                it.message_length = ($urandom_range(0, 1) == 0)
                                    ? mm64_pkg::LEN_W'($urandom)
                                    : mm64_pkg::LEN_W'($urandom_range(0, 64));
                it.last_word      = (i == nwords - 1) || ($urandom_range(0, 5) == 0);
                send_word(it, BY_MODEL, '0);
            end
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        word_ch.valid          = 1'b0;
        word_ch.data_word      = '0;
        word_ch.valid_bytes    = '0;
        word_ch.message_length = '0;
        word_ch.last_word      = 1'b0;
        src_idle_en            = 1'b1;
        snk_idle_en            = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].item, directed_rows[i].src, directed_rows[i].digest);

        while (words_sent < WORD_TARGET)
            send_message();
        word_ch.valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d hashes from %0d words: %0d directed rows, then random messages",
                 hashes_checked, words_sent, NUM_DIRECTED);
        $display("random part mixed well-formed messages with malformed runs, last %0d words unstalled",
                 CALM_WORDS);
        if (errors == 0)
            $display("** murmur64a_hash_unit: PASSED **");
        else
            $display("** murmur64a_hash_unit: FAILED **");
        $finish;
    end

    // hash side back-pressure in bursts
    initial
    begin
        hash_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        hash_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (snk_idle_en && $urandom_range(0, 5) == 0)
            begin
                hash_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                hash_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hash_ch.valid && hash_ch.ready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("hash_value: no hash pending, actual %h", hash_ch.hash_value);
                errors++;
            end
            else
            begin
                digest_head = digest_q.pop_front();
                hashes_checked++;
                if (hash_ch.hash_value !== digest_head)
                begin
                    $error("hash_value: expected %h, actual %h", digest_head, hash_ch.hash_value);
                    errors++;
                end
            end
        end
    end

    // no transaction on either channel for too long means the block is hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_ch.valid && word_ch.ready) || (hash_ch.valid && hash_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transaction", stall_cycles);
                $display("** murmur64a_hash_unit: FAILED **");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: sim.f
sv/mm64_pkg.sv
sv/mm64_if.sv
sv/mm64_ctrl.sv
sv/mm64_datapath.sv
sv/murmur64a_hash_unit.sv
sv/mm64_checker.sv
tb/murmur64a_hash_unit_tb.sv
